[hdl/cmle_pkg.sv]
package cmle_pkg;

    localparam int WORD_W      = 32;
    localparam int LINE_BITS_W = 6;
    localparam int CFG_INDEX_W = 3;

    // saturation points of the link counters and the last data bit index
    localparam logic [6:0] CONFIRM_MAX = 7'd127;
    localparam logic [4:0] ALIGN_MAX   = 5'd31;
    localparam logic [4:0] BIT_LAST    = 5'd31;

    // configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_HEADER_BITS       = 3'd0,
        REG_COMM_RESET_CODE   = 3'd1,
        REG_ROT_RESET_CODE    = 3'd2,
        REG_CUBE_RESET_CODE   = 3'd3,
        REG_CONFIRM_THRESHOLD = 3'd4,
        REG_ALIGN_LIMIT       = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic              command;       // 0 clock sample, 1 load payload word
        logic              clock_level;
        logic              data_bit;
        logic [2:0]        line_index;
        logic [WORD_W-1:0] payload_word;
    } in_beat_t;

    typedef struct packed {
        logic [LINE_BITS_W-1:0] line_bits;
        logic                   word_valid;
        logic                   word_is_command;
        logic [WORD_W-1:0]      received_word;
        logic                   parity_error;
        logic                   rot_reset_pulse;
        logic                   cube_reset_pulse;
        logic [1:0]             link_state;
    } out_beat_t;

endpackage

[hdl/clocked_multiline_link_engine_top.sv]
// Slave end of a serial link clocked by its partner. Each input beat is either a sample of
// the partner clock and data line (command 0) or a payload word for one output line
// (command 1). A sample whose clock level differs from the last one is an edge and yields
// exactly one result beat; loads and non-edge samples yield none. Throughput is one input
// beat per cycle: a beat is registered in the input register, stepped through the link
// state in a single pass and the result lands in the output register. The only thing that
// holds the input side is a stalled, full output register. Configuration writes take
// effect on the next edge and are meant for idle time.
module clocked_multiline_link_engine_top
    import cmle_pkg::*;
#(
    parameter int LINE_COUNT = 6
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // config write port
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]      cfg_data,
    // input beats
    input  logic                   in_valid,
    output logic                   in_stall,
    input  in_beat_t               in_data,
    // result beats
    output logic                   out_valid,
    input  logic                   out_stall,
    output out_beat_t              out_data
);

    localparam int IDX_W = (LINE_COUNT > 1) ? $clog2(LINE_COUNT) : 1;
    localparam logic [3:0] LINE_LIMIT = 4'(LINE_COUNT);

    typedef enum logic [1:0] {
        PH_RESYNC = 2'd0,
        PH_HEADER = 2'd1,
        PH_DATA   = 2'd2,
        PH_PARITY = 2'd3
    } phase_t;

    // configuration
    logic [LINE_BITS_W-1:0] header_bits_reg;
    logic [WORD_W-1:0]      comm_code_reg;
    logic [WORD_W-1:0]      rot_code_reg;
    logic [WORD_W-1:0]      cube_code_reg;
    logic [6:0]             confirm_thr_reg;
    logic [4:0]             align_limit_reg;

    // input register
    logic     in_vld_reg, in_vld_next;
    in_beat_t in_beat_reg;

    // output register
    logic      out_vld_reg, out_vld_next;
    out_beat_t out_beat_reg, out_beat_next;

    // link state
    phase_t                phase_reg, phase_next;
    logic                  prev_clk_reg, prev_clk_next;
    logic [4:0]            bit_idx_reg, bit_idx_next;
    logic [6:0]            confirm_reg, confirm_next;
    logic [4:0]            align_reg, align_next;
    logic                  ack_reg, ack_next;
    logic [WORD_W-1:0]     rx_word_reg, rx_word_next;
    logic                  rx_header_reg, rx_header_next;
    logic                  rx_par_reg, rx_par_next;
    logic [LINE_COUNT-1:0] tx_par_reg, tx_par_next;
    logic                  bad_reg, bad_next;
    logic                  ready_reg, ready_next;
    logic [WORD_W-1:0]     staged_reg [LINE_COUNT];
    logic [WORD_W-1:0]     staged_next [LINE_COUNT];
    logic [WORD_W-1:0]     active_reg [LINE_COUNT];
    logic [WORD_W-1:0]     active_next [LINE_COUNT];

    logic                  step_en;
    logic                  in_accept;
    logic                  edge_seen;
    logic [LINE_COUNT-1:0] drive;
    logic [LINE_COUNT-1:0] lane_bits;
    logic                  word_ok;
    logic                  is_cmd;
    logic                  rot_pulse;
    logic                  cube_pulse;

    // the registered beat moves on unless a result would have nowhere to go
    assign step_en   = in_vld_reg && !(out_vld_reg && out_stall);
    assign in_stall  = in_vld_reg && out_vld_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        in_vld_next = in_accept ? 1'b1 : (step_en ? 1'b0 : in_vld_reg);
    end

    // data bit of each line at the current bit position
    always_comb
    begin
        for (int n = 0; n < LINE_COUNT; n++)
        begin
            lane_bits[n] = active_reg[n][bit_idx_reg];
        end
    end

    // one step of the link per beat
    always_comb
    begin
        phase_next     = phase_reg;
        prev_clk_next  = prev_clk_reg;
        bit_idx_next   = bit_idx_reg;
        confirm_next   = confirm_reg;
        align_next     = align_reg;
        ack_next       = ack_reg;
        rx_word_next   = rx_word_reg;
        rx_header_next = rx_header_reg;
        rx_par_next    = rx_par_reg;
        tx_par_next    = tx_par_reg;
        bad_next       = bad_reg;
        ready_next     = ready_reg;
        staged_next    = staged_reg;
        active_next    = active_reg;
        edge_seen      = 1'b0;
        drive          = '0;
        word_ok        = 1'b0;
        is_cmd         = 1'b0;
        rot_pulse      = 1'b0;
        cube_pulse     = 1'b0;

        if (step_en)
        begin
            if (in_beat_reg.command)
            begin
                if ({1'b0, in_beat_reg.line_index} < LINE_LIMIT)
                begin
                    staged_next[in_beat_reg.line_index[IDX_W-1:0]] = in_beat_reg.payload_word;
                end
            end
            else if (in_beat_reg.clock_level != prev_clk_reg)
            begin
                edge_seen     = 1'b1;
                prev_clk_next = in_beat_reg.clock_level;

                case (phase_reg)
                    PH_RESYNC:
                    begin
                        rx_word_next = '0;
                        if (confirm_reg > confirm_thr_reg)
                        begin
                            // confirmed: wait for two zeros as acknowledge
                            if (align_reg < ALIGN_MAX)
                            begin
                                align_next = align_reg + 5'd1;
                            end
                            if (in_beat_reg.data_bit)
                            begin
                                ack_next = 1'b0;
                                drive    = in_beat_reg.clock_level ? '1 : '0;
                            end
                            else if (!ack_reg)
                            begin
                                ack_next = 1'b1;
                            end
                            else
                            begin
                                phase_next = PH_HEADER;
                                ack_next   = 1'b0;
                            end
                            if (align_next > align_limit_reg && phase_next == PH_RESYNC)
                            begin
                                align_next   = '0;
                                confirm_next = '0;
                                ack_next     = 1'b0;
                            end
                        end
                        else
                        begin
                            // counting ones
                            align_next = '0;
                            ack_next   = 1'b0;
                            drive      = '1;
                            if (!in_beat_reg.data_bit)
                            begin
                                confirm_next = '0;
                            end
                            else if (confirm_reg < CONFIRM_MAX)
                            begin
                                confirm_next = confirm_reg + 7'd1;
                            end
                        end
                    end
                    PH_HEADER:
                    begin
                        confirm_next   = '0;
                        rx_header_next = in_beat_reg.data_bit;
                        drive          = LINE_COUNT'(header_bits_reg);
                        phase_next     = PH_DATA;
                        rx_word_next   = '0;
                        bit_idx_next   = '0;
                    end
                    PH_DATA:
                    begin
                        rx_word_next[bit_idx_reg] = rx_word_reg[bit_idx_reg]
                                                    | in_beat_reg.data_bit;
                        rx_par_next = rx_par_reg ^ in_beat_reg.data_bit;
                        drive       = lane_bits;
                        tx_par_next = tx_par_reg ^ lane_bits;
                        if (bit_idx_reg < BIT_LAST)
                        begin
                            bit_idx_next = bit_idx_reg + 5'd1;
                        end
                        else
                        begin
                            phase_next = PH_PARITY;
                        end
                    end
                    PH_PARITY:
                    begin
                        if (in_beat_reg.data_bit != rx_par_reg)
                        begin
                            bad_next = 1'b1;
                        end
                        drive       = tx_par_reg;
                        tx_par_next = '0;
                        rx_par_next = 1'b0;
                        ready_next  = 1'b1;
                        phase_next  = PH_HEADER;
                    end
                    default:
                    begin
                        phase_next = PH_RESYNC;
                    end
                endcase

                // frame hand-off and command decode
                if (!bad_next && ready_next)
                begin
                    word_ok    = 1'b1;
                    is_cmd     = rx_header_next;
                    ready_next = 1'b0;
                    if (rx_header_next)
                    begin
                        if (rx_word_next == comm_code_reg)
                        begin
                            phase_next = PH_RESYNC;
                        end
                        else if (rx_word_next == rot_code_reg)
                        begin
                            rot_pulse = 1'b1;
                        end
                        else if (rx_word_next == cube_code_reg)
                        begin
                            cube_pulse = 1'b1;
                        end
                    end
                end
                else if (rx_word_next == comm_code_reg)
                begin
                    phase_next = PH_RESYNC;
                end
            end

            // line words go live at the start of each data phase
            if (phase_next == PH_DATA && bit_idx_next == '0)
            begin
                active_next = staged_next;
            end
        end
    end

    always_comb
    begin
        out_beat_next.line_bits        = LINE_BITS_W'(drive);
        out_beat_next.word_valid       = word_ok;
        out_beat_next.word_is_command  = is_cmd;
        out_beat_next.received_word    = rx_word_next;
        out_beat_next.parity_error     = bad_next;
        out_beat_next.rot_reset_pulse  = rot_pulse;
        out_beat_next.cube_reset_pulse = cube_pulse;
        out_beat_next.link_state       = 2'(phase_next);
        out_vld_next = edge_seen ? 1'b1 : (out_stall ? out_vld_reg : 1'b0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_bits_reg <= '0;
            comm_code_reg   <= 32'd1;
            rot_code_reg    <= 32'd2;
            cube_code_reg   <= 32'd3;
            confirm_thr_reg <= 7'd64;
            align_limit_reg <= 5'd16;
            in_vld_reg      <= 1'b0;
            out_vld_reg     <= 1'b0;
            phase_reg       <= PH_RESYNC;
            prev_clk_reg    <= 1'b0;
            bit_idx_reg     <= '0;
            confirm_reg     <= '0;
            align_reg       <= '0;
            ack_reg         <= 1'b0;
            rx_word_reg     <= '0;
            rx_header_reg   <= 1'b0;
            rx_par_reg      <= 1'b0;
            tx_par_reg      <= '0;
            bad_reg         <= 1'b0;
            ready_reg       <= 1'b0;
            for (int n = 0; n < LINE_COUNT; n++)
            begin
                staged_reg[n] <= '0;
                active_reg[n] <= '0;
            end
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_HEADER_BITS:       header_bits_reg <= cfg_data[LINE_BITS_W-1:0];
                    REG_COMM_RESET_CODE:   comm_code_reg   <= cfg_data;
                    REG_ROT_RESET_CODE:    rot_code_reg    <= cfg_data;
                    REG_CUBE_RESET_CODE:   cube_code_reg   <= cfg_data;
                    REG_CONFIRM_THRESHOLD: confirm_thr_reg <= cfg_data[6:0];
                    REG_ALIGN_LIMIT:       align_limit_reg <= cfg_data[4:0];
                    default:               ;
                endcase
            end
            in_vld_reg    <= in_vld_next;
            out_vld_reg   <= out_vld_next;
            phase_reg     <= phase_next;
            prev_clk_reg  <= prev_clk_next;
            bit_idx_reg   <= bit_idx_next;
            confirm_reg   <= confirm_next;
            align_reg     <= align_next;
            ack_reg       <= ack_next;
            rx_word_reg   <= rx_word_next;
            rx_header_reg <= rx_header_next;
            rx_par_reg    <= rx_par_next;
            tx_par_reg    <= tx_par_next;
            bad_reg       <= bad_next;
            ready_reg     <= ready_next;
            staged_reg    <= staged_next;
            active_reg    <= active_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_beat_reg <= in_data;
        end
        if (edge_seen)
        begin
            out_beat_reg <= out_beat_next;
        end
    end

    assign out_valid = out_vld_reg;
    assign out_data  = out_beat_reg;

endmodule

[tb/sv/tb_clocked_multiline_link_engine_top.sv]
`timescale 1ns / 1ps

module tb_clocked_multiline_link_engine_top
    import cmle_pkg::*;
;

    localparam int LINE_COUNT     = 6;
    localparam int SETTLE_CYCLES  = 4;     // input and output registers plus margin
    localparam int HOLD_CYCLES    = 80;    // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no beat on either side

    // link phases as reported on link_state
    typedef enum logic [1:0] {
        LINK_RESYNC = 2'd0,
        LINK_HEADER = 2'd1,
        LINK_DATA   = 2'd2,
        LINK_PARITY = 2'd3
    } link_phase_t;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_write;
    cfg_reg_t   cfg_index;
    logic [31:0] cfg_data;
    logic       in_valid;
    logic       in_stall;
    in_beat_t   in_data;
    logic       out_valid;
    logic       out_stall;
    out_beat_t  out_data;

    clocked_multiline_link_engine_top #(
        .LINE_COUNT(LINE_COUNT)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Link predictor: register copies and link state, stepped once per
    // accepted input beat. Each partner clock edge queues one result.
    // ------------------------------------------------------------------
    logic [5:0]  hdr_bits_r;
    logic [31:0] comm_code_r, rot_code_r, cube_code_r;
    logic [6:0]  confirm_thr_r;
    logic [4:0]  align_lim_r;

    link_phase_t lk_phase;
    logic        lk_prev_clk;
    logic [4:0]  lk_bit_idx;
    logic [6:0]  lk_confirm;
    logic [4:0]  lk_align;
    logic        lk_ack;
    logic [31:0] lk_rx_word;
    logic        lk_rx_hdr, lk_rx_par, lk_bad, lk_ready;
    logic [5:0]  lk_tx_par;
    logic [31:0] staged_words_m [LINE_COUNT];
    logic [31:0] active_words_m [LINE_COUNT];

    out_beat_t   pending_edges [$];

    int beats_sent, results_checked, frames_seen, rot_pulses, cube_pulses, mismatch_count;

    // stimulus knobs
    logic send_gaps, stall_gaps, hold_request;
    int   load_pct, bad_pct;
    logic        frm_hdr, frm_bad;
    logic [31:0] frm_word;

    task automatic reset_link_model();
        hdr_bits_r    = '0;
        comm_code_r   = 32'd1;
        rot_code_r    = 32'd2;
        cube_code_r   = 32'd3;
        confirm_thr_r = 7'd64;
        align_lim_r   = 5'd16;
        lk_phase      = LINK_RESYNC;
        lk_prev_clk   = 1'b0;
        lk_bit_idx    = '0;
        lk_confirm    = '0;
        lk_align      = '0;
        lk_ack        = 1'b0;
        lk_rx_word    = '0;
        lk_rx_hdr     = 1'b0;
        lk_rx_par     = 1'b0;
        lk_bad        = 1'b0;
        lk_ready      = 1'b0;
        lk_tx_par     = '0;
        for (int n = 0; n < LINE_COUNT; n++)
        begin
            staged_words_m[n] = '0;
            active_words_m[n] = '0;
        end
    endtask

    // staged words move to the active set whenever a step ends at data bit 0
    task automatic latch_active();
        if (lk_phase == LINK_DATA && lk_bit_idx == 5'd0)
        begin
            for (int n = 0; n < LINE_COUNT; n++)
                active_words_m[n] = staged_words_m[n];
        end
    endtask

    task automatic advance_link(input in_beat_t b);
        logic [7:0] drv;
        logic       vld, cmd, rp, cp;
        out_beat_t  r;
        drv = '0;
        vld = 1'b0;
        cmd = 1'b0;
        rp  = 1'b0;
        cp  = 1'b0;
        if (b.command)
        begin
            if (b.line_index < LINE_COUNT)
                staged_words_m[b.line_index] = b.payload_word;
            latch_active();
            return;
        end
        if (b.clock_level == lk_prev_clk)
        begin
            latch_active();
            return;
        end
        lk_prev_clk = b.clock_level;

        case (lk_phase)
            LINK_RESYNC:
            begin
                lk_rx_word = '0;
                if (lk_confirm > confirm_thr_r)
                begin
                    // aligning: wait for two zeros in a row
                    if (lk_align < ALIGN_MAX)
                        lk_align++;
                    if (b.data_bit)
                    begin
                        lk_ack = 1'b0;
                        drv    = b.clock_level ? 8'hFF : 8'h00;
                    end
                    else if (!lk_ack)
                        lk_ack = 1'b1;
                    else
                    begin
                        lk_phase = LINK_HEADER;
                        lk_ack   = 1'b0;
                    end
                    if (lk_align > align_lim_r && lk_phase == LINK_RESYNC)
                    begin
                        lk_align   = '0;
                        lk_confirm = '0;
                        lk_ack     = 1'b0;
                    end
                end
                else
                begin
                    // counting ones
                    lk_align = '0;
                    lk_ack   = 1'b0;
                    drv      = 8'hFF;
                    if (b.data_bit)
                    begin
                        if (lk_confirm < CONFIRM_MAX)
                            lk_confirm++;
                    end
                    else
                        lk_confirm = '0;
                end
            end
            LINK_HEADER:
            begin
                lk_confirm = '0;
                lk_rx_hdr  = b.data_bit;
                drv        = {2'b00, hdr_bits_r};
                lk_phase   = LINK_DATA;
                lk_rx_word = '0;
                lk_bit_idx = '0;
            end
            LINK_DATA:
            begin
                lk_rx_word[lk_bit_idx] = lk_rx_word[lk_bit_idx] | b.data_bit;
                lk_rx_par = lk_rx_par ^ b.data_bit;
                for (int n = 0; n < LINE_COUNT; n++)
                    if (active_words_m[n][lk_bit_idx])
                        drv[n] = 1'b1;
                lk_tx_par = lk_tx_par ^ drv[5:0];
                if (lk_bit_idx < BIT_LAST)
                    lk_bit_idx++;
                else
                    lk_phase = LINK_PARITY;
            end
            default:
            begin
                if (b.data_bit != lk_rx_par)
                    lk_bad = 1'b1;
                drv       = {2'b00, lk_tx_par};
                lk_tx_par = '0;
                lk_rx_par = 1'b0;
                lk_ready  = 1'b1;
                lk_phase  = LINK_HEADER;
            end
        endcase

        if (!lk_bad && lk_ready)
        begin
            vld = 1'b1;
            cmd = lk_rx_hdr;
            if (lk_rx_hdr)
            begin
                // reset code wins over rotation, rotation over counter
                if (lk_rx_word == comm_code_r)
                    lk_phase = LINK_RESYNC;
                else if (lk_rx_word == rot_code_r)
                    rp = 1'b1;
                else if (lk_rx_word == cube_code_r)
                    cp = 1'b1;
            end
            lk_ready = 1'b0;
        end
        else if (lk_rx_word == comm_code_r)
            lk_phase = LINK_RESYNC;

        latch_active();

        r.line_bits        = drv[5:0];
        r.word_valid       = vld;
        r.word_is_command  = cmd;
        r.received_word    = lk_rx_word;
        r.parity_error     = lk_bad;
        r.rot_reset_pulse  = rp;
        r.cube_reset_pulse = cp;
        r.link_state       = lk_phase;
        pending_edges.push_back(r);
    endtask

    // ------------------------------------------------------------------
    // Stimulus. The partner side is played from the predicted link
    // state so that most edges form proper resync and frame sequences.
    // ------------------------------------------------------------------
    function automatic in_beat_t pick_link_beat();
        in_beat_t b;
        int       roll;
        logic     dbit;
        b.command      = 1'b0;
        b.clock_level  = ~lk_prev_clk;
        b.data_bit     = 1'($urandom);
        b.line_index   = 3'($urandom_range(0, 7));
        b.payload_word = $urandom;
        roll = $urandom_range(0, 99);
        if (roll < load_pct)
        begin
            b.command = 1'b1;
            return b;
        end
        if (roll < load_pct + 3)
        begin
            b.clock_level = lk_prev_clk;   // no edge
            return b;
        end
        case (lk_phase)
            LINK_RESYNC:
                if (lk_confirm > confirm_thr_r)
                    dbit = ($urandom_range(0, 7) == 0);   // mostly the ack zeros
                else
                    dbit = ($urandom_range(0, 19) != 0);  // mostly ones
            LINK_HEADER:
            begin
                frm_hdr = ($urandom_range(0, 2) == 0);
                if (frm_hdr)
                begin
                    case ($urandom_range(0, 3))
                        0:       frm_word = comm_code_r;
                        1:       frm_word = rot_code_r;
                        2:       frm_word = cube_code_r;
                        default: frm_word = $urandom;
                    endcase
                end
                else
                    frm_word = ($urandom_range(0, 15) == 0) ? rot_code_r : $urandom;
                frm_bad = ($urandom_range(0, 99) < bad_pct);
                dbit    = frm_hdr;
            end
            LINK_DATA:
                dbit = frm_word[lk_bit_idx];
            default:
                dbit = lk_rx_par ^ frm_bad;
        endcase
        b.data_bit = dbit;
        return b;
    endfunction

    task automatic send_beat(input in_beat_t b);
        int gap;
        if (send_gaps && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 13);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        else
            @(negedge clk);
        in_valid <= 1'b1;
        in_data  <= b;
        do
            @(posedge clk);
        while (in_stall);
        advance_link(b);
        beats_sent++;
    endtask

    task automatic send_edge(input logic dbit);
        in_beat_t b;
        b.command      = 1'b0;
        b.clock_level  = ~lk_prev_clk;
        b.data_bit     = dbit;
        b.line_index   = 3'($urandom_range(0, 7));
        b.payload_word = $urandom;
        send_beat(b);
    endtask

    task automatic send_load(input logic [2:0] idx, input logic [31:0] word);
        in_beat_t b;
        b.command      = 1'b1;
        b.clock_level  = 1'($urandom);
        b.data_bit     = 1'($urandom);
        b.line_index   = idx;
        b.payload_word = word;
        send_beat(b);
    endtask

    task automatic run_traffic(input int count);
        repeat (count) send_beat(pick_link_beat());
    endtask

    // sender rests until every queued result is back, then lets the pipe settle
    task automatic drain_link();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_edges.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [31:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        case (idx)
            REG_HEADER_BITS:       hdr_bits_r    = value[5:0];
            REG_COMM_RESET_CODE:   comm_code_r   = value;
            REG_ROT_RESET_CODE:    rot_code_r    = value;
            REG_CUBE_RESET_CODE:   cube_code_r   = value;
            REG_CONFIRM_THRESHOLD: confirm_thr_r = value[6:0];
            REG_ALIGN_LIMIT:       align_lim_r   = value[4:0];
            default: ;
        endcase
    endtask

    // high bit set keeps a code from matching a partially received word
    function automatic logic [31:0] wide_code();
        return $urandom | 32'h8000_0000;
    endfunction

    // ------------------------------------------------------------------
    // Receiver stall: random bursts, or one long hold-off on request.
    // ------------------------------------------------------------------
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                out_stall <= 1'b0;
            end
            else if (stall_gaps && $urandom_range(0, 9) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(negedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checking against the oldest queued expectation
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("[%0t] mismatch, %s: got %h expected %h (result %0d)",
                     $realtime, what, got, want, results_checked);
    endtask

    always @(posedge clk)
    begin
        out_beat_t w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_edges.size() == 0)
                report_mismatch("result with nothing pending", out_data.received_word, '0);
            else
            begin
                w = pending_edges.pop_front();
                if (out_data.line_bits !== w.line_bits)
                    report_mismatch("line_bits", out_data.line_bits, w.line_bits);
                if (out_data.word_valid !== w.word_valid)
                    report_mismatch("word_valid", out_data.word_valid, w.word_valid);
                if (out_data.word_is_command !== w.word_is_command)
                    report_mismatch("word_is_command", out_data.word_is_command,
                                    w.word_is_command);
                if (out_data.received_word !== w.received_word)
                    report_mismatch("received_word", out_data.received_word,
                                    w.received_word);
                if (out_data.parity_error !== w.parity_error)
                    report_mismatch("parity_error", out_data.parity_error, w.parity_error);
                if (out_data.rot_reset_pulse !== w.rot_reset_pulse)
                    report_mismatch("rot_reset_pulse", out_data.rot_reset_pulse,
                                    w.rot_reset_pulse);
                if (out_data.cube_reset_pulse !== w.cube_reset_pulse)
                    report_mismatch("cube_reset_pulse", out_data.cube_reset_pulse,
                                    w.cube_reset_pulse);
                if (out_data.link_state !== w.link_state)
                    report_mismatch("link_state", out_data.link_state, w.link_state);
                if (w.word_valid)
                    frames_seen++;
                if (w.rot_reset_pulse)
                    rot_pulses++;
                if (w.cube_reset_pulse)
                    cube_pulses++;
            end
            results_checked++;
        end
    end

    // watchdog: too long with no beat moving on either side
    int quiet_cycles;
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // field extremes, ignored loads, no-edge sample, confirm count reset,
    // alignment giving up, ack, header, and a load that lands on data bit 0
    task automatic test_directed_corners();
        in_beat_t b;
        write_reg(REG_CONFIRM_THRESHOLD, 32'd1);
        write_reg(REG_ALIGN_LIMIT, 32'd1);
        send_load(3'd0, 32'h0000_0000);
        send_load(3'd5, 32'hFFFF_FFFF);
        send_load(3'd6, 32'hFFFF_FFFF);   // beyond the last line: dropped
        send_load(3'd7, 32'h0000_0000);
        send_load(3'd2, 32'hA5A5_5A5A);
        b.command      = 1'b0;
        b.clock_level  = lk_prev_clk;     // same level as before: no edge
        b.data_bit     = 1'b1;
        b.line_index   = 3'd7;
        b.payload_word = 32'hFFFF_FFFF;
        send_beat(b);
        send_edge(1'b1);
        send_edge(1'b0);                  // count of ones starts over
        send_edge(1'b1);
        send_edge(1'b1);                  // count now above threshold
        send_edge(1'b1);                  // aligning, drive follows clock
        send_edge(1'b1);                  // align limit passed: restart
        send_edge(1'b1);
        send_edge(1'b1);
        send_edge(1'b0);
        send_edge(1'b0);                  // ack complete
        send_edge(1'b1);                  // command header
        send_load(3'd1, 32'hFFFF_0000);   // latched while at data bit 0
        send_edge(1'b1);
        send_edge(1'b0);
        drain_link();
    endtask

    task automatic test_frame_traffic();
        write_reg(REG_HEADER_BITS, 32'h2A);
        write_reg(REG_COMM_RESET_CODE, wide_code());
        write_reg(REG_ROT_RESET_CODE, wide_code());
        write_reg(REG_CUBE_RESET_CODE, wide_code());
        write_reg(REG_CONFIRM_THRESHOLD, 32'd2);
        write_reg(REG_ALIGN_LIMIT, 32'd31);
        run_traffic(260);
        drain_link();
    endtask

    // threshold at its top: the saturated count never exceeds it
    task automatic test_confirm_ceiling();
        write_reg(REG_HEADER_BITS, 32'h3F);
        write_reg(REG_COMM_RESET_CODE, 32'hFFFF_FFFF);
        write_reg(REG_CONFIRM_THRESHOLD, 32'd127);
        run_traffic(150);
        drain_link();
    endtask

    // rotation and counter codes equal; long receiver hold-off mid-way
    task automatic test_shared_codes_backpressure();
        logic [31:0] code;
        code = wide_code();
        write_reg(REG_HEADER_BITS, 32'h00);
        write_reg(REG_ROT_RESET_CODE, code);
        write_reg(REG_CUBE_RESET_CODE, code);
        write_reg(REG_CONFIRM_THRESHOLD, 32'd1);
        write_reg(REG_ALIGN_LIMIT, 32'd1);
        run_traffic(80);
        hold_request = 1'b1;
        send_gaps    = 1'b0;
        run_traffic(60);
        send_gaps    = 1'b1;
        run_traffic(60);
        drain_link();
    endtask

    // reset code zero: the cleared word matches it, so the link never leaves resync
    task automatic test_zero_reset_code();
        write_reg(REG_COMM_RESET_CODE, 32'h0);
        write_reg(REG_CONFIRM_THRESHOLD, 32'd2);
        write_reg(REG_ALIGN_LIMIT, 32'd16);
        run_traffic(40);
        drain_link();
    endtask

    // bad parity latches; afterwards no frame is accepted and only the reset code sends the link to resync
    task automatic test_sticky_parity();
        write_reg(REG_HEADER_BITS, 32'h15);
        write_reg(REG_COMM_RESET_CODE, 32'h5);
        write_reg(REG_ROT_RESET_CODE, wide_code());
        write_reg(REG_CUBE_RESET_CODE, wide_code());
        write_reg(REG_CONFIRM_THRESHOLD, 32'd3);
        send_gaps  = 1'b0;
        stall_gaps = 1'b0;
        bad_pct    = 25;
        run_traffic(200);
        drain_link();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        cfg_write    = 1'b0;
        cfg_index    = REG_HEADER_BITS;
        cfg_data     = '0;
        in_valid     = 1'b0;
        in_data      = '0;
        send_gaps    = 1'b1;
        stall_gaps   = 1'b1;
        hold_request = 1'b0;
        load_pct     = 12;
        bad_pct      = 0;
        frm_hdr      = 1'b0;
        frm_bad      = 1'b0;
        frm_word     = '0;
        reset_link_model();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_corners();
        test_frame_traffic();
        test_confirm_ceiling();
        test_shared_codes_backpressure();
        test_zero_reset_code();
        test_sticky_parity();

        if (pending_edges.size() != 0)
            report_mismatch("results never arrived", pending_edges.size(), 0);
        $display("run: %0d input beats, %0d edge results checked, %0d frames accepted",
                 beats_sent, results_checked, frames_seen);
        $display("run: %0d rotation and %0d counter pulses, parity error latched %0d",
                 rot_pulses, cube_pulses, lk_bad);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
